@@ design/btsc_pkg.sv @@
// Shared constants, opcodes and helper functions for the binary trie counter.
// No dependencies; imported by the trie top level and the checker.
`default_nettype none

package btsc_pkg;

  // Fixed field widths of the command and result beats
  localparam int CNT_W    = 32;
  localparam int KEY_W    = 32;
  localparam int BITCNT_W = 6;
  // Depth counter covers a walk of up to 64 levels plus the leaf step
  localparam int DEPTH_W  = 7;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  // Saturating count increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
    sat_inc = (cnt == {CNT_W{1'b1}}) ? cnt : cnt + CNT_W'(1);
  endfunction

  // Key bit that steers the branch at a given depth; bits past the key read as 0
  function automatic logic key_bit(input logic [KEY_W-1:0] key,
                                   input logic [DEPTH_W-1:0] depth);
    key_bit = (depth < DEPTH_W'(KEY_W)) ? key[depth[4:0]] : 1'b0;
  endfunction

endpackage

`default_nettype wire

@@ design/btsc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module btsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/binary_trie_suffix_counter.sv @@
// Top level of the binary trie suffix counter: walk sequencer and node memory.
// Depends on btsc_pkg and btsc_ram.
//
// Channel   Ports                                     Handshake
// command   in_op, in_value, in_bit_count             start && !busy
// result    out_match_count, out_full_res             out_valid, one cycle, no stall
//
// An insert walks from the root through KEY_BITS levels to the leaf, doing one node
// read-modify-write per level (existing children are read through the node RAM's read
// port, fresh ones are allocated), then shows its result beat. A query walks down
// bit_count levels, or ends early when the path ends, then shows its result beat.
// A refused insert reports full in the cycle after accept. busy is high during a walk and
// drops in the result cycle, so the next command is taken at the edge that ends it.
// The root node sits in flip-flops cleared by reset; every other node is written when
// it is allocated, so no clearing pass is needed. Results cannot be stalled.
`default_nettype none

module binary_trie_suffix_counter
  import btsc_pkg::*;
#(
  parameter int NODE_POOL = 65536,
  parameter int KEY_BITS  = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_op,
  input  wire logic [KEY_W-1:0]    in_value,
  input  wire logic [BITCNT_W-1:0] in_bit_count,
  output logic                     out_valid,
  output logic [CNT_W-1:0]         out_match_count,
  output logic                     out_full_res
);

  localparam int IW = $clog2(NODE_POOL);
  localparam int NW = IW + 1;
  localparam int EW = CNT_W + 2 * IW;
  localparam logic [NW-1:0]      FULL_LIMIT = NW'(NODE_POOL - KEY_BITS - 1);
  localparam logic [DEPTH_W-1:0] LEAF_DEPTH = DEPTH_W'(KEY_BITS);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t              state_r, state_nxt;
  logic                op_r, op_nxt;
  logic [KEY_W-1:0]    value_r, value_nxt;
  logic [BITCNT_W-1:0] levels_r, levels_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [NW-1:0]       nfree_r, nfree_nxt;
  logic                from_ram_r, from_ram_nxt;
  logic [IW-1:0]       cur_idx_r, cur_idx_nxt;
  logic [CNT_W-1:0]    cur_cnt_r, cur_cnt_nxt;
  logic [IW-1:0]       cur_z_r, cur_z_nxt;
  logic [IW-1:0]       cur_o_r, cur_o_nxt;
  logic [CNT_W-1:0]    root_cnt_r, root_cnt_nxt;
  logic [IW-1:0]       root_z_r, root_z_nxt;
  logic [IW-1:0]       root_o_r, root_o_nxt;
  logic                valid_r, valid_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                full_r, full_nxt;

  logic                ram_wr_en;
  logic [IW-1:0]       ram_wr_addr;
  logic [EW-1:0]       ram_wr_data;
  logic                ram_rd_en;
  logic [IW-1:0]       ram_rd_addr;
  logic [EW-1:0]       ram_rd_data;

  logic [CNT_W-1:0]    node_cnt;
  logic [IW-1:0]       node_z;
  logic [IW-1:0]       node_o;
  logic                br_bit;
  logic [IW-1:0]       child;
  logic [CNT_W-1:0]    cnt_inc;
  logic [IW-1:0]       new_z;
  logic [IW-1:0]       new_o;
  logic                wb_en;

  // Node memory: entry is {count, zero child, one child}
  btsc_ram #(
    .WIDTH (EW),
    .DEPTH (NODE_POOL)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Current node comes from the RAM read just issued or from the held copy
  assign node_cnt = from_ram_r ? ram_rd_data[EW-1 -: CNT_W] : cur_cnt_r;
  assign node_z   = from_ram_r ? ram_rd_data[2*IW-1 -: IW]  : cur_z_r;
  assign node_o   = from_ram_r ? ram_rd_data[IW-1:0]        : cur_o_r;
  assign br_bit   = key_bit(value_r, depth_r);
  assign child    = br_bit ? node_o : node_z;
  assign cnt_inc  = sat_inc(node_cnt);

  // Walk sequencer: one level per cycle
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    value_nxt    = value_r;
    levels_nxt   = levels_r;
    depth_nxt    = depth_r;
    nfree_nxt    = nfree_r;
    from_ram_nxt = 1'b0;
    cur_idx_nxt  = cur_idx_r;
    cur_cnt_nxt  = node_cnt;
    cur_z_nxt    = node_z;
    cur_o_nxt    = node_o;
    root_cnt_nxt = root_cnt_r;
    root_z_nxt   = root_z_r;
    root_o_nxt   = root_o_r;
    valid_nxt    = 1'b0;
    count_nxt    = count_r;
    full_nxt     = full_r;
    new_z        = node_z;
    new_o        = node_o;
    wb_en        = 1'b0;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = child;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt      = in_op;
          value_nxt   = in_value;
          levels_nxt  = in_bit_count;
          depth_nxt   = '0;
          cur_idx_nxt = '0;
          cur_cnt_nxt = root_cnt_r;
          cur_z_nxt   = root_z_r;
          cur_o_nxt   = root_o_r;
          if (in_op == OP_INSERT && nfree_r > FULL_LIMIT) begin
            // Refuse the insert, nothing changes
            valid_nxt = 1'b1;
            count_nxt = '0;
            full_nxt  = 1'b1;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (op_r == OP_INSERT) begin
          wb_en = 1'b1;
          if (depth_r == LEAF_DEPTH) begin
            // Bump the leaf and finish
            state_nxt = ST_IDLE;
            valid_nxt = 1'b1;
            count_nxt = '0;
            full_nxt  = 1'b0;
          end else begin
            depth_nxt = depth_r + DEPTH_W'(1);
            if (child == '0) begin
              // Allocate a fresh node and link it to the parent
              cur_idx_nxt = nfree_r[IW-1:0];
              nfree_nxt   = nfree_r + NW'(1);
              cur_cnt_nxt = '0;
              cur_z_nxt   = '0;
              cur_o_nxt   = '0;
              if (br_bit) begin
                new_o = nfree_r[IW-1:0];
              end else begin
                new_z = nfree_r[IW-1:0];
              end
            end else begin
              cur_idx_nxt  = child;
              ram_rd_en    = 1'b1;
              from_ram_nxt = 1'b1;
            end
          end
        end else begin
          if (depth_r == {1'b0, levels_r}) begin
            state_nxt = ST_IDLE;
            valid_nxt = 1'b1;
            count_nxt = node_cnt;
            full_nxt  = 1'b0;
          end else if (child == '0) begin
            // Path ends before the requested depth
            state_nxt = ST_IDLE;
            valid_nxt = 1'b1;
            count_nxt = '0;
            full_nxt  = 1'b0;
          end else begin
            depth_nxt    = depth_r + DEPTH_W'(1);
            cur_idx_nxt  = child;
            ram_rd_en    = 1'b1;
            from_ram_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Write back the updated node: root stays in flops, the rest in RAM
    if (wb_en && cur_idx_r == '0) begin
      root_cnt_nxt = cnt_inc;
      root_z_nxt   = new_z;
      root_o_nxt   = new_o;
    end
  end

  assign ram_wr_en   = wb_en && (cur_idx_r != '0);
  assign ram_wr_addr = cur_idx_r;
  assign ram_wr_data = {cnt_inc, new_z, new_o};

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    value_r   <= value_nxt;
    levels_r  <= levels_nxt;
    depth_r   <= depth_nxt;
    cur_idx_r <= cur_idx_nxt;
    cur_cnt_r <= cur_cnt_nxt;
    cur_z_r   <= cur_z_nxt;
    cur_o_r   <= cur_o_nxt;
    count_r   <= count_nxt;
    full_r    <= full_nxt;
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      nfree_r    <= NW'(1);
      from_ram_r <= 1'b0;
      root_cnt_r <= '0;
      root_z_r   <= '0;
      root_o_r   <= '0;
      valid_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      nfree_r    <= nfree_nxt;
      from_ram_r <= from_ram_nxt;
      root_cnt_r <= root_cnt_nxt;
      root_z_r   <= root_z_nxt;
      root_o_r   <= root_o_nxt;
      valid_r    <= valid_nxt;
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = valid_r;
  assign out_match_count = count_r;
  assign out_full_res    = full_r;

endmodule

`default_nettype wire

@@ design/btsc_checker.sv @@
// Port-level checks on the binary trie suffix counter, bound to its top level.
// Depends on btsc_pkg.
`default_nettype none

module btsc_checker
  import btsc_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                in_op,
  input wire logic                out_valid,
  input wire logic [CNT_W-1:0]    out_match_count,
  input wire logic                out_full_res
);

  // A walk always ends with its result beat
  a_walk_ends_in_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("walk ended without a result beat");

  // No result beat while a walk is still running
  a_beat_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat during a walk");

  // A refused insert carries a zero count
  a_full_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_full_res) |-> (out_match_count == '0))
    else $error("full result with nonzero count");

  // An accepted query always starts a walk
  a_query_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_QUERY) |=> busy || (out_valid && !out_full_res))
    else $error("query did not start a walk");

  // An accepted insert either walks or is refused at once
  a_insert_walks_or_full: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_INSERT) |=> (busy || (out_valid && out_full_res)))
    else $error("insert neither walked nor was refused");

endmodule

bind binary_trie_suffix_counter btsc_checker u_btsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_match_count (out_match_count),
  .out_full_res    (out_full_res)
);

`default_nettype wire
